[sv/run_length_text_encoder_macros.svh]
// ---------------------------------------------------------------------------
// Run-length text encoder assertion macros
// Shared assertion forms for the encoder's checkers.
// ---------------------------------------------------------------------------
`ifndef RUN_LENGTH_TEXT_ENCODER_MACROS_SVH
`define RUN_LENGTH_TEXT_ENCODER_MACROS_SVH

// same-cycle implication
`define RLTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RLTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/rlte_pkg.sv]
// ---------------------------------------------------------------------------
// Run-length text encoder package
// Word types, run record, slot codes and the decimal split helper.
// ---------------------------------------------------------------------------
package rlte_pkg;

	localparam int RUN_W       = 7;
	localparam int MAX_RUN_DEF = 99;
	localparam int QUEUE_DEPTH = 4;
	localparam int SLOTS       = 6;

	localparam logic [7:0]       DIGIT_ZERO = 8'h30;
	localparam logic [RUN_W-1:0] TEN        = 7'd10;

	localparam logic [SLOTS-1:0] SLOT_C_BYTE  = 6'b000001;
	localparam logic [SLOTS-1:0] SLOT_C_TENS  = 6'b000010;
	localparam logic [SLOTS-1:0] SLOT_C_UNITS = 6'b000100;
	localparam logic [SLOTS-1:0] SLOT_F_BYTE  = 6'b001000;
	localparam logic [SLOTS-1:0] SLOT_F_TENS  = 6'b010000;
	localparam logic [SLOTS-1:0] SLOT_F_UNITS = 6'b100000;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last_symbol;
	} sym_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} enc_word_t;

	typedef struct packed {
		logic [7:0]       c_byte;
		logic [3:0]       c_tens;
		logic [3:0]       c_units;
		logic [7:0]       f_byte;
		logic [3:0]       f_tens;
		logic [3:0]       f_units;
		logic [SLOTS-1:0] mask;
	} run_rec_t;

	// {tens, units} of a run length below 100
	function automatic logic [7:0] dec_split(input logic [RUN_W-1:0] n);
		logic [14:0]      prod;
		logic [3:0]       tens;
		logic [RUN_W-1:0] rem;
		prod = 15'(n) * 15'd205;
		tens = prod[14:11];
		rem  = n - ({3'b000, tens} * TEN);
		return {tens, rem[3:0]};
	endfunction

endpackage

[sv/rlte_front.sv]
// ---------------------------------------------------------------------------
// Run-length text encoder front
// Tracks the open run; a word that closes it or ends a string makes a record.
// ---------------------------------------------------------------------------
module rlte_front #(
	parameter int MAX_RUN = rlte_pkg::MAX_RUN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  rlte_pkg::sym_word_t word,
	output logic                push,
	output rlte_pkg::run_rec_t  rec
);

	logic [7:0]                 held_q;
	logic [rlte_pkg::RUN_W-1:0] len_q;
	logic                       closing;
	logic [7:0]                 new_held;
	logic [rlte_pkg::RUN_W-1:0] new_len;
	logic [7:0]                 c_split;
	logic [7:0]                 f_split;

	always_comb begin
		closing  = 1'b0;
		new_held = word.symbol;
		new_len  = 7'd1;
		if (len_q != '0) begin
			if (word.symbol == held_q && len_q < rlte_pkg::RUN_W'(MAX_RUN)) begin
				new_held = held_q;
				new_len  = len_q + 7'd1;
			end else begin
				closing = 1'b1;
			end
		end
	end

	assign c_split = rlte_pkg::dec_split(len_q);
	assign f_split = rlte_pkg::dec_split(new_len);

	always_comb begin
		rec.c_byte  = held_q;
		rec.c_tens  = c_split[7:4];
		rec.c_units = c_split[3:0];
		rec.f_byte  = new_held;
		rec.f_tens  = f_split[7:4];
		rec.f_units = f_split[3:0];
		rec.mask[0] = closing;
		rec.mask[1] = closing && len_q >= rlte_pkg::TEN;
		rec.mask[2] = closing && len_q > 7'd1;
		rec.mask[3] = word.last_symbol;
		rec.mask[4] = word.last_symbol && new_len >= rlte_pkg::TEN;
		rec.mask[5] = word.last_symbol && new_len > 7'd1;
	end

	assign push = accept && (rec.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			len_q  <= '0;
		end else if (accept) begin
			held_q <= new_held;
			len_q  <= word.last_symbol ? '0 : new_len;
		end
	end

endmodule

[sv/rlte_queue.sv]
// ---------------------------------------------------------------------------
// Run-length text encoder queue
// Short record queue between the front and the back.
// ---------------------------------------------------------------------------
module rlte_queue #(
	parameter int DEPTH = rlte_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rlte_pkg::run_rec_t push_rec,
	input  logic               pop,
	output logic               not_empty,
	output logic               full,
	output rlte_pkg::run_rec_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rlte_pkg::run_rec_t mem_q [DEPTH];
	logic [PW-1:0]      wr_q;
	logic [PW-1:0]      rd_q;
	logic [CW-1:0]      cnt_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign not_empty = cnt_q != '0;
	assign full      = cnt_q == CW'(DEPTH);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[sv/rlte_back.sv]
// ---------------------------------------------------------------------------
// Run-length text encoder back
// Expands run records into output words, one word per cycle unless stalled.
// ---------------------------------------------------------------------------
module rlte_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  rlte_pkg::run_rec_t  q_head,
	output logic                pop,
	output logic                enc_valid,
	input  logic                enc_stall,
	output rlte_pkg::enc_word_t enc_word
);

	rlte_pkg::run_rec_t          rec_q;
	logic [rlte_pkg::SLOTS-1:0]  mask_q;
	rlte_pkg::enc_word_t         out_q;
	logic                        out_valid_q;
	logic                        out_free;
	logic                        emit;
	logic [rlte_pkg::SLOTS-1:0]  low;
	logic [rlte_pkg::SLOTS-1:0]  rest;
	logic [rlte_pkg::SLOTS-1:0]  mask_after;
	logic [7:0]                  sel_byte;

	assign out_free   = !out_valid_q || !enc_stall;
	assign emit       = out_free && (mask_q != '0);
	assign low        = mask_q & (~mask_q + 6'd1);
	assign rest       = mask_q & ~low;
	assign mask_after = emit ? rest : mask_q;
	assign pop        = (mask_after == '0) && q_valid;

	always_comb begin
		case (low)
			rlte_pkg::SLOT_C_BYTE:  sel_byte = rec_q.c_byte;
			rlte_pkg::SLOT_C_TENS:  sel_byte = rlte_pkg::DIGIT_ZERO + {4'h0, rec_q.c_tens};
			rlte_pkg::SLOT_C_UNITS: sel_byte = rlte_pkg::DIGIT_ZERO + {4'h0, rec_q.c_units};
			rlte_pkg::SLOT_F_BYTE:  sel_byte = rec_q.f_byte;
			rlte_pkg::SLOT_F_TENS:  sel_byte = rlte_pkg::DIGIT_ZERO + {4'h0, rec_q.f_tens};
			rlte_pkg::SLOT_F_UNITS: sel_byte = rlte_pkg::DIGIT_ZERO + {4'h0, rec_q.f_units};
			default:                sel_byte = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= q_head;
		end
		if (emit) begin
			out_q.out_byte <= sel_byte;
			out_q.out_last <= rec_q.mask[3] && (rest == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mask_q <= pop ? q_head.mask : mask_after;
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	assign enc_valid = out_valid_q;
	assign enc_word  = out_q;

endmodule

[sv/run_length_text_encoder.sv]
// ---------------------------------------------------------------------------
// Run-length text encoder
// Top level: front, record queue and back.
// ---------------------------------------------------------------------------
// Takes one text byte per cycle and writes each run as its byte followed,
// for runs longer than one, by one or two ASCII decimal digits of its
// length; runs close at MAX_RUN bytes and the final output word of a string
// carries out_last. An input word is taken every cycle while the record
// queue (Q_DEPTH entries) has room; the output side delivers one word per
// cycle while enc_stall is low, so a run never costs more output cycles
// than input cycles. When the word closing a run is taken, its record is
// written into the queue; it is then loaded into the back, and its first
// output word is registered after that. A busy back or a stalled output
// can hold the record between these steps.
// ---------------------------------------------------------------------------
module run_length_text_encoder #(
	parameter int MAX_RUN = rlte_pkg::MAX_RUN_DEF,
	parameter int Q_DEPTH = rlte_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sym_valid,
	output logic                sym_stall,
	input  rlte_pkg::sym_word_t sym_word,
	output logic                enc_valid,
	input  logic                enc_stall,
	output rlte_pkg::enc_word_t enc_word
);

	logic               accept;
	logic               push;
	rlte_pkg::run_rec_t push_rec;
	logic               pop;
	logic               q_valid;
	logic               q_full;
	rlte_pkg::run_rec_t q_head;

	assign sym_stall = q_full;
	assign accept    = sym_valid && !q_full;

	rlte_front #(
		.MAX_RUN(MAX_RUN)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.word  (sym_word),
		.push  (push),
		.rec   (push_rec)
	);

	rlte_queue #(
		.DEPTH(Q_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.not_empty(q_valid),
		.full     (q_full),
		.head     (q_head)
	);

	rlte_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.pop      (pop),
		.enc_valid(enc_valid),
		.enc_stall(enc_stall),
		.enc_word (enc_word)
	);

endmodule

[sv/rlte_checker.sv]
// ---------------------------------------------------------------------------
// Run-length text encoder checker
// Port-level checks, bound to the top level.
// ---------------------------------------------------------------------------
`include "run_length_text_encoder_macros.svh"

module rlte_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                sym_valid,
	input logic                sym_stall,
	input rlte_pkg::sym_word_t sym_word,
	input logic                enc_valid,
	input logic                enc_stall,
	input rlte_pkg::enc_word_t enc_word
);

	`RLTE_ASSERT_NEXT(a_reset_quiet, clk, 1'b1, !arst_n, !enc_valid && !sym_stall, "busy in reset")
	`RLTE_ASSERT_NOW(a_stall_backed, clk, arst_n, sym_stall, enc_valid, "stall with no output")
	`RLTE_ASSERT_NEXT(a_out_hold, clk, arst_n, enc_valid && enc_stall,
		enc_valid && $stable(enc_word), "stalled word changed")

endmodule

bind run_length_text_encoder rlte_checker u_rlte_checker (.*);

[tb/run_length_text_encoder_tb.sv]
// ---------------------------------------------------------------------------
// Run-length text encoder testbench
// Sends strings of text words through the encoder under random sender gaps
// and receiver stalls. A local run tracker predicts every encoded word, and
// each word that leaves the block is compared with the oldest prediction.
// Covered: single-byte strings, runs with one and two length digits, runs
// that may close at the run limit, and strings that end right after a run
// closes. Some strings are held back until all earlier output has drained.
// ---------------------------------------------------------------------------
module run_length_text_encoder_tb;

	localparam int         RUN_LIMIT      = 99;
	localparam logic [7:0] ASCII_ZERO     = 8'h30;
	localparam int         RANDOM_SYMBOLS = 450;
	localparam int         IDLE_LIMIT     = 4000;
	localparam int         TAIL_CYCLES    = 20;
	localparam int         PRINT_LIMIT    = 40;

	typedef struct packed {
		logic                drain;
		rlte_pkg::sym_word_t w;
	} sym_item_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                sym_valid = 1'b0;
	logic                sym_stall;
	rlte_pkg::sym_word_t sym_word  = '0;
	logic                enc_valid;
	logic                enc_stall = 1'b0;
	rlte_pkg::enc_word_t enc_word;

	sym_item_t           sym_queue[$];
	rlte_pkg::enc_word_t enc_expected[$];
	logic [7:0]          run_sym     = '0;
	logic [6:0]          run_len     = '0;
	int                  mismatches  = 0;
	int unsigned         cyc         = 0;
	int                  tx_hold     = 0;
	int                  rx_hold     = 0;
	int                  idle_cycles = 0;

	run_length_text_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.sym_valid(sym_valid),
		.sym_stall(sym_stall),
		.sym_word(sym_word),
		.enc_valid(enc_valid),
		.enc_stall(enc_stall),
		.enc_word(enc_word)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) cyc <= cyc + 1;

	function automatic int pick_gap(input logic calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic queue_symbol(input logic [7:0] sym, input logic fin, input logic drain);
		sym_item_t item;
		item.drain         = drain;
		item.w.symbol      = sym;
		item.w.last_symbol = fin;
		sym_queue.push_back(item);
	endtask

	task automatic push_run(input logic [7:0] b, input logic [6:0] n, input logic fin);
		rlte_pkg::enc_word_t w;
		w.out_byte = b;
		w.out_last = fin && n <= 7'd1;
		enc_expected.push_back(w);
		if (n > 7'd1) begin
			if (n >= 7'd10) begin
				w.out_byte = ASCII_ZERO + 8'(n / 7'd10);
				w.out_last = 1'b0;
				enc_expected.push_back(w);
			end
			w.out_byte = ASCII_ZERO + 8'(n % 7'd10);
			w.out_last = fin;
			enc_expected.push_back(w);
		end
	endtask

	task automatic encode_symbol(input rlte_pkg::sym_word_t w);
		if (run_len == 7'd0) begin
			run_sym = w.symbol;
			run_len = 7'd1;
		end else if (w.symbol == run_sym && run_len < RUN_LIMIT) begin
			run_len = run_len + 7'd1;
		end else begin
			push_run(run_sym, run_len, 1'b0);
			run_sym = w.symbol;
			run_len = 7'd1;
		end
		if (w.last_symbol) begin
			push_run(run_sym, run_len, 1'b1);
			run_len = 7'd0;
		end
	endtask

	task automatic report_mismatch(input string what, input rlte_pkg::enc_word_t got,
			input rlte_pkg::enc_word_t want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch (%0s) at cycle %0d: got %h/%b, want %h/%b", what, cyc,
				got.out_byte, got.out_last, want.out_byte, want.out_last);
	endtask

	always @(posedge clk or negedge arst_n) begin : sym_driver
		sym_item_t nxt;
		if (!arst_n) begin
			sym_valid <= 1'b0;
			sym_word  <= '0;
		end else begin
			if (sym_valid && !sym_stall) begin
				encode_symbol(sym_word);
				tx_hold = pick_gap(cyc[8:7] == 2'b00);
			end
			if (!sym_valid || !sym_stall) begin
				if (tx_hold != 0) begin
					tx_hold--;
					sym_valid <= 1'b0;
				end else if (sym_queue.size() != 0 &&
						(!sym_queue[0].drain || enc_expected.size() == 0)) begin
					nxt = sym_queue.pop_front();
					sym_word  <= nxt.w;
					sym_valid <= 1'b1;
				end else begin
					sym_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : enc_receiver
		if (!arst_n) begin
			enc_stall <= 1'b0;
		end else begin
			if (rx_hold != 0)
				rx_hold--;
			else
				rx_hold = pick_gap(cyc[9:8] == 2'b00);
			enc_stall <= (rx_hold != 0);
		end
	end

	always @(posedge clk) begin : enc_monitor
		rlte_pkg::enc_word_t want;
		if (arst_n && enc_valid && !enc_stall) begin
			if (enc_expected.size() == 0) begin
				report_mismatch("unexpected word", enc_word, '0);
			end else begin
				want = enc_expected.pop_front();
				if (enc_word.out_byte !== want.out_byte)
					report_mismatch("out_byte", enc_word, want);
				if (enc_word.out_last !== want.out_last)
					report_mismatch("out_last", enc_word, want);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((sym_valid && !sym_stall) || (enc_valid && !enc_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int         n_random;
		int         n_runs;
		int         len;
		int         sel;
		logic [7:0] b;
		logic       drain;

		queue_symbol(8'h01, 1'b1, 1'b0);
		queue_symbol(8'hff, 1'b1, 1'b0);
		queue_symbol("A", 1'b0, 1'b0);
		queue_symbol("A", 1'b0, 1'b0);
		queue_symbol("B", 1'b1, 1'b0);
		queue_symbol("x", 1'b0, 1'b0);
		queue_symbol("y", 1'b0, 1'b0);
		queue_symbol("y", 1'b1, 1'b0);
		for (int i = 0; i < 10; i++)
			queue_symbol("C", 1'b0, 1'b0);
		queue_symbol("D", 1'b0, 1'b0);
		queue_symbol("D", 1'b1, 1'b0);
		queue_symbol(8'h7f, 1'b0, 1'b0);
		queue_symbol(8'h80, 1'b1, 1'b0);
		queue_symbol("E", 1'b0, 1'b0);
		queue_symbol("E", 1'b0, 1'b0);
		queue_symbol("E", 1'b1, 1'b0);

		// hold this string until all earlier words have drained
		len = $urandom_range(98, 101);
		b   = 8'($urandom_range(1, 255));
		for (int i = 0; i < len; i++)
			queue_symbol(b, i == len - 1, i == 0);
		n_random = len;

		while (n_random < RANDOM_SYMBOLS) begin
			drain = ($urandom_range(0, 39) == 0);
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					queue_symbol(8'($urandom_range(1, 255)),
						i == len - 1 || $urandom_range(0, 5) == 0, drain);
					drain = 1'b0;
				end
				n_random += len;
			end else begin
				n_runs = $urandom_range(1, 6);
				for (int r = 0; r < n_runs; r++) begin
					if ($urandom_range(0, 2) == 0)
						b = 8'($urandom_range(1, 255));
					else
						b = 8'h61 + 8'($urandom_range(0, 3));
					sel = $urandom_range(0, 99);
					if (sel < 60)
						len = $urandom_range(1, 3);
					else if (sel < 90)
						len = $urandom_range(4, 15);
					else if (sel < 97)
						len = $urandom_range(16, 40);
					else
						len = $urandom_range(95, 105);
					for (int i = 0; i < len; i++) begin
						queue_symbol(b, r == n_runs - 1 && i == len - 1, drain);
						drain = 1'b0;
					end
					n_random += len;
				end
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (sym_queue.size() != 0 || sym_valid)
			@(posedge clk);
		while (enc_expected.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
